// ----- rtl/cfd_pkg.sv -----
// Shared types, constants and the CRC byte update of the CRC-16 frame deframer.
`default_nettype none

package cfd_pkg;

  localparam int HdrBytes = 5;

  localparam logic [2:0] PhHunt    = 3'd0;
  localparam logic [2:0] PhSeenAa  = 3'd1;
  localparam logic [2:0] PhHeader  = 3'd2;
  localparam logic [2:0] PhPayload = 3'd3;
  localparam logic [2:0] PhCrcHi   = 3'd4;
  localparam logic [2:0] PhCrcLo   = 3'd5;

  localparam logic [7:0]  MagicFirst      = 8'hAA;
  localparam logic [7:0]  MagicSecond     = 8'h55;
  localparam logic [15:0] CrcInit         = 16'hFFFF;
  localparam logic [15:0] CrcPoly         = 16'hA001;
  localparam logic [31:0] MaxPayloadReset = 32'h4000_0000;

  typedef logic [HdrBytes-1:0][7:0] hdr_t;

  typedef struct packed {
    logic [2:0]  phase;
    logic [2:0]  hdr_cnt;
    logic [31:0] left;
    logic [15:0] crc;
    logic [7:0]  crc_hi;
  } state_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] out_byte;
    logic       is_payload;
    logic       frame_end;
    logic       crc_good;
  } result_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/cfd_step.sv -----
// Next-state and result logic of the deframer for one received byte.
`default_nettype none

module cfd_step (
  input  cfd_pkg::state_t  state_i,
  input  cfd_pkg::hdr_t    hdr_i,
  input  logic [7:0]       data_byte_i,
  input  logic [31:0]      max_len_i,
  output cfd_pkg::state_t  state_o,
  output cfd_pkg::hdr_t    hdr_o,
  output cfd_pkg::result_t res_o
);

  logic [2:0]    cnt;
  cfd_pkg::hdr_t hdr_w;
  logic [31:0]   len;
  logic [31:0]   left_dec;
  logic [15:0]   crc_next;
  logic          found;
  logic [1:0]    idx;

  always_comb begin
    cnt = (state_i.hdr_cnt >= 3'(cfd_pkg::HdrBytes)) ? 3'd0 : state_i.hdr_cnt;
    hdr_w = hdr_i;
    hdr_w[cnt] = data_byte_i;
    len = {hdr_w[1], hdr_w[2], hdr_w[3], hdr_w[4]};
    left_dec = state_i.left - 32'd1;
    crc_next = cfd_pkg::crc_byte(state_i.crc, data_byte_i);

    found = 1'b0;
    idx = 2'd0;
    for (int i = 3; i >= 0; i--) begin
      if (hdr_w[i] == cfd_pkg::MagicFirst && hdr_w[i+1] == cfd_pkg::MagicSecond) begin
        found = 1'b1;
        idx = 2'(i);
      end
    end

    state_o = state_i;
    hdr_o = hdr_i;
    res_o = '0;

    case (state_i.phase)
      cfd_pkg::PhSeenAa: begin
        if (data_byte_i == cfd_pkg::MagicSecond) begin
          state_o.hdr_cnt = 3'd0;
          state_o.phase = cfd_pkg::PhHeader;
        end else if (data_byte_i != cfd_pkg::MagicFirst) begin
          state_o.phase = cfd_pkg::PhHunt;
        end
      end
      cfd_pkg::PhHeader: begin
        hdr_o = hdr_w;
        if (cnt != 3'(cfd_pkg::HdrBytes - 1)) begin
          state_o.hdr_cnt = cnt + 3'd1;
        end else if (len > max_len_i) begin
          // The magic is dropped and the stored header is searched again.
          if (found) begin
            case (idx)
              2'd0: begin
                hdr_o[0] = hdr_w[2];
                hdr_o[1] = hdr_w[3];
                hdr_o[2] = hdr_w[4];
              end
              2'd1: begin
                hdr_o[0] = hdr_w[3];
                hdr_o[1] = hdr_w[4];
              end
              2'd2: hdr_o[0] = hdr_w[4];
              default: hdr_o = hdr_w;
            endcase
            state_o.hdr_cnt = 3'd3 - {1'b0, idx};
            state_o.phase = cfd_pkg::PhHeader;
          end else begin
            state_o.hdr_cnt = 3'd0;
            state_o.phase = (hdr_w[4] == cfd_pkg::MagicFirst) ? cfd_pkg::PhSeenAa
                                                              : cfd_pkg::PhHunt;
          end
        end else begin
          state_o.hdr_cnt = 3'd0;
          state_o.crc = cfd_pkg::CrcInit;
          state_o.left = len;
          state_o.phase = (len == 32'd0) ? cfd_pkg::PhCrcHi : cfd_pkg::PhPayload;
        end
      end
      cfd_pkg::PhPayload: begin
        state_o.crc = crc_next;
        state_o.left = left_dec;
        if (left_dec == 32'd0) begin
          state_o.phase = cfd_pkg::PhCrcHi;
        end
        res_o.valid = 1'b1;
        res_o.out_byte = data_byte_i;
        res_o.is_payload = 1'b1;
      end
      cfd_pkg::PhCrcHi: begin
        state_o.crc_hi = data_byte_i;
        state_o.phase = cfd_pkg::PhCrcLo;
      end
      cfd_pkg::PhCrcLo: begin
        res_o.valid = 1'b1;
        res_o.frame_end = 1'b1;
        res_o.crc_good = ({state_i.crc_hi, data_byte_i} == state_i.crc);
        state_o.phase = cfd_pkg::PhHunt;
        state_o.crc = cfd_pkg::CrcInit;
      end
      default: begin
        state_o.phase = (data_byte_i == cfd_pkg::MagicFirst) ? cfd_pkg::PhSeenAa
                                                             : cfd_pkg::PhHunt;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/crc16_frame_deframer.sv -----
// Top level of the CRC-16 length-prefixed frame deframer.
// The deframer takes one byte per cycle and gives at most one result per byte: each
// payload byte as it arrives, and an end result with the CRC verdict after the second
// CRC byte. A byte passes an input register, the header, length and CRC-16 update logic,
// and a result register. Its result enters the result register when the byte leaves
// the input register, and from there the result can leave downstream. A new byte is taken
// every cycle; the input stalls only while the result register holds a request that
// downstream stalls. Payload leaves before its check, so downstream must discard a
// frame whose end result shows a bad CRC. The limit on the payload length may be
// written at any time the deframer is idle.
`default_nettype none

module crc16_frame_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        is_payload_o,
  output logic        frame_end_o,
  output logic        crc_good_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_max_payload_length_i
);

  logic             in_valid_q;
  logic [7:0]       in_byte_q;
  logic [31:0]      max_len_q;
  cfd_pkg::state_t  state_q;
  cfd_pkg::state_t  state_d;
  cfd_pkg::hdr_t    hdr_q;
  cfd_pkg::hdr_t    hdr_d;
  cfd_pkg::result_t res_d;
  logic             out_valid_q;
  logic [7:0]       out_byte_q;
  logic             is_payload_q;
  logic             frame_end_q;
  logic             crc_good_q;
  logic             out_free;
  logic             adv;
  logic             take;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign adv         = in_valid_q && out_free;
  assign in_stall_o  = in_valid_q && !out_free;
  assign take        = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  cfd_step u_step (
    .state_i     (state_q),
    .hdr_i       (hdr_q),
    .data_byte_i (in_byte_q),
    .max_len_i   (max_len_q),
    .state_o     (state_d),
    .hdr_o       (hdr_d),
    .res_o       (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
      max_len_q      <= cfd_pkg::MaxPayloadReset;
      state_q.phase  <= cfd_pkg::PhHunt;
      state_q.hdr_cnt <= 3'd0;
      state_q.left   <= 32'd0;
      state_q.crc    <= cfd_pkg::CrcInit;
      state_q.crc_hi <= 8'd0;
    end else begin
      if (take) begin
        in_valid_q <= 1'b1;
      end else if (adv) begin
        in_valid_q <= 1'b0;
      end
      if (out_free) begin
        out_valid_q <= adv && res_d.valid;
      end
      if (adv) begin
        state_q <= state_d;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        max_len_q <= cfg_max_payload_length_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_byte_q <= data_byte_i;
    end
    if (adv) begin
      hdr_q <= hdr_d;
    end
    if (adv && res_d.valid && out_free) begin
      out_byte_q   <= res_d.out_byte;
      is_payload_q <= res_d.is_payload;
      frame_end_q  <= res_d.frame_end;
      crc_good_q   <= res_d.crc_good;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign is_payload_o = is_payload_q;
  assign frame_end_o  = frame_end_q;
  assign crc_good_o   = crc_good_q;

endmodule

`default_nettype wire

// ----- rtl/cfd_checker.sv -----
// Port-level checker for the CRC-16 frame deframer and its bind to the top level.
`default_nettype none

module cfd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [7:0]  data_byte_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  out_byte_o,
  input logic        is_payload_o,
  input logic        frame_end_o,
  input logic        crc_good_o
);

  // A stalled byte request keeps its contents.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(data_byte_i))
    else $error("input changed while stalled");

  // A stalled result request keeps its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o) &&
    $stable(is_payload_o) && $stable(frame_end_o) && $stable(crc_good_o))
    else $error("result changed while stalled");

  // Every result is either a payload byte or a frame end, never both.
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_payload_o != frame_end_o))
    else $error("result kind is not exclusive");

  // Payload results carry no verdict, and end results carry no byte.
  a_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_payload_o ? !crc_good_o : (out_byte_o == 8'h00)))
    else $error("result fields inconsistent with kind");

  // The input is held back only while a result request waits downstream.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without downstream backpressure");

endmodule

bind crc16_frame_deframer cfd_checker u_cfd_checker (.*);

`default_nettype wire
